>>> src/gsr_pkg.sv
// ----------------------------------------------------------------------------
// gsr_pkg
// Shared types and constants of the GCLOCK slot replacement unit: payload
// structs, use levels, operation and status codes, controller interface.
// ----------------------------------------------------------------------------
package gsr_pkg;

    localparam int NUM_SLOTS_DEF = 256;
    localparam int CFG_W         = 9;
    localparam int IDX_W         = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_VISIT = 1'b1;

    localparam logic [1:0] STAT_ALLOC = 2'd0;
    localparam logic [1:0] STAT_VISIT = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic [1:0] LVL_EMPTY = 2'd0;
    localparam logic [1:0] LVL_IDLE  = 2'd1;
    localparam logic [1:0] LVL_INUSE = 2'd2;
    localparam logic [1:0] LVL_BUSY  = 2'd3;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] slot_index;
    } req_item_t;

    typedef struct packed {
        logic [IDX_W-1:0] chosen_slot;
        logic [1:0]       status;
    } rsp_item_t;

    typedef struct packed {
        logic clr;
        logic load;
        logic rd;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic done;
        logic out_free;
    } dp_stat_t;

endpackage

>>> src/gclock_slot_replacement_unit.sv
// ----------------------------------------------------------------------------
// gclock_slot_replacement_unit
// GCLOCK slot replacement policy over a fixed set of slots.
// ----------------------------------------------------------------------------
// The request channel (req_valid, req_ready, req) carries one operation per
// beat: allocate a slot, or visit the slot given by slot_index. The response
// channel (rsp_valid, rsp_ready, rsp) returns one beat per request with the
// chosen or echoed slot and a status code. The slot count register is
// written through cfg_we and cfg_wdata; the user must write it only while
// the unit is idle, which the unit itself does not enforce. A visit is
// accepted, its slot level is read and evaluated, and its result is written
// to the response register with rsp_valid high. An allocate repeats the
// read and evaluate steps for every busy or in-use slot the hand passes,
// since each such slot costs one read and one write of the level memory.
// The next request is taken only once the previous one has reached the
// response register: no new item is taken before the last one is through.
// After reset a clearing pass writes every slot to empty, one per cycle,
// with req_ready low; configuration writes are taken during it. When the
// receiver stalls, the response beat is held and the unit finishes the next
// item up to the point where it must hand over its result, then waits.
// ----------------------------------------------------------------------------
module gclock_slot_replacement_unit
    import gsr_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  req_item_t        req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_item_t        rsp,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    gsr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    gsr_datapath #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

>>> src/gsr_ctrl.sv
// ----------------------------------------------------------------------------
// gsr_ctrl
// Controller of the slot replacement unit: clearing pass after reset, item
// acceptance, and the read and evaluate loop of the hand.
// ----------------------------------------------------------------------------
module gsr_ctrl
    import gsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  dp_stat_t  stat,
    output ctrl_cmd_t cmd
);

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EVAL  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                if (stat.done)
                begin
                    if (stat.out_free)
                    begin
                        cmd.finish = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/gsr_datapath.sv
// ----------------------------------------------------------------------------
// gsr_datapath
// Datapath of the slot replacement unit: slot level memory, hand, slot count
// register, item registers and the response register.
// ----------------------------------------------------------------------------
module gsr_datapath
    import gsr_pkg::*;
#(
    parameter int NUM_SLOTS = NUM_SLOTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  req_item_t        req,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output rsp_item_t        rsp,
    input  ctrl_cmd_t        cmd,
    output dp_stat_t         stat
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int CNT_W  = $clog2(NUM_SLOTS + 1);
    localparam int EW     = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    logic [1:0]        mem [NUM_SLOTS];
    logic [CFG_W-1:0]  cfg_reg;
    logic [SLOT_W-1:0] hand_reg;
    logic              started_reg;
    logic [SLOT_W-1:0] clr_reg;
    logic [SLOT_W-1:0] pos_reg;
    logic              op_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [1:0]        rd_data_reg;
    rsp_item_t         rsp_reg;
    logic              rsp_valid_reg;

    logic [CNT_W-1:0]  eff_count;
    logic              out_range;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_wa;
    logic [1:0]        mem_wd;

    function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] p,
                                                   input logic [CNT_W-1:0]  n);
        logic [SLOT_W:0] nxt;
        nxt = {1'b0, p} + (SLOT_W+1)'(1);
        if (nxt >= (SLOT_W+1)'(n))
        begin
            return '0;
        end
        return nxt[SLOT_W-1:0];
    endfunction

    always_comb
    begin
        if (cfg_reg == '0 || EW'(cfg_reg) > EW'(NUM_SLOTS))
        begin
            eff_count = CNT_W'(NUM_SLOTS);
        end
        else
        begin
            eff_count = CNT_W'(cfg_reg);
        end
    end

    assign out_range = EW'(idx_reg) >= EW'(eff_count);

    assign stat.clear_last = (clr_reg == SLOT_W'(NUM_SLOTS - 1));
    assign stat.done       = (op_reg == OP_VISIT) || !started_reg
                             || (rd_data_reg == LVL_EMPTY) || (rd_data_reg == LVL_IDLE);
    assign stat.out_free   = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = pos_reg;
        mem_wd = LVL_INUSE;
        if (cmd.clr)
        begin
            mem_we = 1'b1;
            mem_wa = clr_reg;
            mem_wd = LVL_EMPTY;
        end
        else if (cmd.step)
        begin
            mem_we = 1'b1;
            mem_wd = rd_data_reg - 2'd1;
        end
        else if (cmd.finish)
        begin
            if (op_reg == OP_ALLOC)
            begin
                mem_we = 1'b1;
            end
            else if (!out_range && (rd_data_reg == LVL_IDLE || rd_data_reg == LVL_INUSE))
            begin
                mem_we = 1'b1;
                mem_wd = rd_data_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[pos_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            hand_reg      <= '0;
            started_reg   <= 1'b0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                cfg_reg <= cfg_wdata;
            end
            if (cmd.clr)
            begin
                clr_reg <= clr_reg + SLOT_W'(1);
            end
            if (cmd.finish && op_reg == OP_ALLOC)
            begin
                hand_reg    <= pos_reg;
                started_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= req.operation;
            idx_reg <= req.slot_index;
            if (req.operation == OP_VISIT)
            begin
                pos_reg <= SLOT_W'(req.slot_index);
            end
            else if (started_reg)
            begin
                pos_reg <= wrap_inc(hand_reg, eff_count);
            end
            else
            begin
                pos_reg <= '0;
            end
        end
        else if (cmd.step)
        begin
            pos_reg <= wrap_inc(pos_reg, eff_count);
        end
        if (cmd.finish)
        begin
            if (op_reg == OP_ALLOC)
            begin
                rsp_reg.chosen_slot <= IDX_W'(pos_reg);
                rsp_reg.status      <= STAT_ALLOC;
            end
            else
            begin
                rsp_reg.chosen_slot <= idx_reg;
                rsp_reg.status      <= out_range ? STAT_RANGE : STAT_VISIT;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> rsp_valid_reg)
        else $error("Response beat not presented after finish.");

    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!rsp_valid_reg || rsp_ready))
        else $error("Response register overwritten while stalled.");

    a_hand_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.rd && op_reg == OP_ALLOC) |-> (CNT_W'(pos_reg) < eff_count))
        else $error("Allocation hand outside the swept slots.");

    a_started_stays: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(started_reg))
        else $error("Hand started flag cleared outside reset.");
`endif

endmodule

>>> sim/gclock_tracker_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gclock_tracker_pkg
// Software copy of the GCLOCK slot policy for the unit testbench. It keeps
// its own slot levels, hand and slot count, predicts the response to every
// accepted request beat, and checks response beats against that prediction.
// ----------------------------------------------------------------------------
package gclock_tracker_pkg;

    import gsr_pkg::*;

    class gclock_tracker;

        logic [1:0]       slot_level [NUM_SLOTS_DEF];
        logic [IDX_W-1:0] hand;
        bit               hand_started;
        logic [CFG_W-1:0] slot_count;
        rsp_item_t        pending_grants [$];
        int unsigned      mismatches;
        int unsigned      grants_checked;

        function new();
            foreach (slot_level[i])
            begin
                slot_level[i] = LVL_EMPTY;
            end
            hand           = '0;
            hand_started   = 1'b0;
            slot_count     = CFG_RESET;
            mismatches     = 0;
            grants_checked = 0;
        endfunction

        function void set_slot_count(logic [CFG_W-1:0] value);
            slot_count = value;
        endfunction

        function int unsigned sweep_span();
            if (slot_count == 0 || slot_count > NUM_SLOTS_DEF)
            begin
                return NUM_SLOTS_DEF;
            end
            return slot_count;
        endfunction

        function int unsigned pending();
            return pending_grants.size();
        endfunction

        function logic [IDX_W-1:0] sweep_hand();
            int unsigned n;
            int unsigned pos;
            logic [1:0]  lvl;
            n   = sweep_span();
            pos = hand;
            if (!hand_started)
            begin
                hand_started  = 1'b1;
                hand          = '0;
                slot_level[0] = LVL_INUSE;
                return '0;
            end
            for (int unsigned guard = 0; guard < 3 * n + 2; guard++)
            begin
                pos = pos + 1;
                if (pos >= n)
                begin
                    pos = 0;
                end
                lvl = slot_level[pos];
                if (lvl == LVL_EMPTY || lvl == LVL_IDLE)
                begin
                    break;
                end
                slot_level[pos] = lvl - 2'd1;
            end
            hand            = pos[IDX_W-1:0];
            slot_level[pos] = LVL_INUSE;
            return pos[IDX_W-1:0];
        endfunction

        function void note_request(req_item_t item);
            rsp_item_t grant;
            if (item.operation == OP_ALLOC)
            begin
                grant.chosen_slot = sweep_hand();
                grant.status      = STAT_ALLOC;
            end
            else
            begin
                grant.chosen_slot = item.slot_index;
                if (item.slot_index >= sweep_span())
                begin
                    grant.status = STAT_RANGE;
                end
                else
                begin
                    if (slot_level[item.slot_index] == LVL_IDLE ||
                        slot_level[item.slot_index] == LVL_INUSE)
                    begin
                        slot_level[item.slot_index] = slot_level[item.slot_index] + 2'd1;
                    end
                    grant.status = STAT_VISIT;
                end
            end
            pending_grants.push_back(grant);
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_grant(rsp_item_t got);
            rsp_item_t want;
            if (pending_grants.size() == 0)
            begin
                report_mismatch($sformatf("response beat slot %0d status %0d with no request open",
                                          got.chosen_slot, got.status));
                return;
            end
            want = pending_grants.pop_front();
            grants_checked++;
            if (got.chosen_slot !== want.chosen_slot)
            begin
                report_mismatch($sformatf("chosen_slot %0d, predicted %0d",
                                          got.chosen_slot, want.chosen_slot));
            end
            if (got.status !== want.status)
            begin
                report_mismatch($sformatf("status %0d, predicted %0d for slot %0d",
                                          got.status, want.status, want.chosen_slot));
            end
        endtask

    endclass

endpackage

>>> sim/tb_gclock_slot_replacement_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gclock_slot_replacement_unit
// Self-checking testbench of the GCLOCK slot replacement unit. A directed
// pass walks the slot levels, the wrap of the hand and every slot count
// corner; random phases then mix allocates and visits under several idle
// profiles and one long response hold-off, each beat checked on arrival.
// ----------------------------------------------------------------------------
module tb_gclock_slot_replacement_unit;

    import gsr_pkg::*;
    import gclock_tracker_pkg::*;

    localparam int     CLK_PERIOD_NS   = 8;
    localparam int     RESET_CYCLES    = 4;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam int     DRAIN_CYCLES    = 40;
    localparam int     PHASE_ITEMS     = 100;
    localparam int     NUM_PHASES      = 10;
    localparam longint TIMEOUT_NS      = 64'd60_000_000;

    logic             clk;
    logic             rst_n;
    logic             req_valid;
    logic             req_ready;
    req_item_t        req;
    logic             rsp_valid;
    logic             rsp_ready;
    rsp_item_t        rsp;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned hold_requests;
    int unsigned hold_seen;
    int unsigned hold_left;
    int unsigned beats_sent;
    int unsigned count_writes;

    gclock_tracker tracker;

    gclock_slot_replacement_unit #(
        .NUM_SLOTS (NUM_SLOTS_DEF)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD_NS / 2) clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        rsp_ready = 1'b0;
        hold_seen = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_seen)
            begin
                hold_seen = hold_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid && rsp_ready)
            begin
                tracker.check_grant(rsp);
            end
            if (req_valid && req_ready)
            begin
                tracker.note_request(req);
            end
            if (cfg_we)
            begin
                tracker.set_slot_count(cfg_wdata);
            end
        end
    end

    task automatic send_beat(input logic op, input logic [IDX_W-1:0] idx);
        int unsigned gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
        begin
            gap++;
        end
        if (gap != 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid      <= 1'b1;
        req.operation  <= op;
        req.slot_index <= idx;
        do
        begin
            @(posedge clk);
        end
        while (!req_ready);
        beats_sent++;
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (2) @(posedge clk);
    endtask

    task automatic write_slot_count(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        count_writes++;
    endtask

    task automatic run_directed();
        send_beat(OP_VISIT, 8'd0);
        send_beat(OP_VISIT, 8'd255);
        send_beat(OP_ALLOC, 8'd255);
        send_beat(OP_ALLOC, 8'd0);
        send_beat(OP_VISIT, 8'd0);
        send_beat(OP_VISIT, 8'd0);
        send_beat(OP_VISIT, 8'd1);
        send_beat(OP_ALLOC, 8'd0);
        send_beat(OP_VISIT, 8'd2);
        send_beat(OP_ALLOC, 8'd0);
        write_slot_count(9'd2);
        send_beat(OP_ALLOC, 8'd0);
        send_beat(OP_VISIT, 8'd2);
        send_beat(OP_VISIT, 8'd255);
        send_beat(OP_VISIT, 8'd1);
        send_beat(OP_ALLOC, 8'd255);
        write_slot_count(9'd1);
        send_beat(OP_ALLOC, 8'd0);
        send_beat(OP_VISIT, 8'd0);
        send_beat(OP_VISIT, 8'd1);
        send_beat(OP_ALLOC, 8'd0);
        write_slot_count(9'd0);
        send_beat(OP_VISIT, 8'd255);
        send_beat(OP_ALLOC, 8'd0);
        write_slot_count(9'd511);
        send_beat(OP_VISIT, 8'd255);
        send_beat(OP_ALLOC, 8'd0);
        send_beat(OP_ALLOC, 8'd0);
    endtask

    task automatic send_random_beat();
        int unsigned pick;
        int unsigned span;
        logic [IDX_W-1:0] idx;
        pick = $urandom_range(99);
        span = tracker.sweep_span();
        idx  = IDX_W'($urandom_range(255));
        if (pick < 45)
        begin
            send_beat(OP_ALLOC, idx);
        end
        else if (pick < 90)
        begin
            if (span > 64 && $urandom_range(1) == 1)
            begin
                idx = IDX_W'($urandom_range(63));
            end
            else
            begin
                idx = IDX_W'($urandom_range(span - 1));
            end
            send_beat(OP_VISIT, idx);
        end
        else
        begin
            send_beat(OP_VISIT, idx);
        end
    endtask

    task automatic run_random();
        logic [CFG_W-1:0] counts [NUM_PHASES];
        counts = '{9'd256, 9'd1, 9'd2, 9'd0, 9'd511, 9'd16, 9'd256, 9'd5, 9'd256, 9'd3};
        counts[NUM_PHASES-1] = CFG_W'($urandom_range(255, 3));
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_slot_count(counts[p]);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (p == 6)
            begin
                hold_requests++;
            end
            repeat (PHASE_ITEMS) send_random_beat();
        end
    endtask

    initial
    begin
        tracker        = new();
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req            = '0;
        cfg_we         = 1'b0;
        cfg_wdata      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_requests  = 0;
        beats_sent     = 0;
        count_writes   = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d request beats and %0d checked responses across %0d slot counts,",
                 beats_sent, tracker.grants_checked, count_writes);
        $display("four idle profiles and a %0d cycle response hold-off.", HOLD_OFF_CYCLES);
        if (tracker.mismatches == 0 && tracker.pending() == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
